>>> sv/fla_pkg.sv
// Package: shared constants, types and codes of the free-list block allocator.
package fla_pkg;
	localparam int TABLE_ENTRIES = 64;
	localparam int ADDR_BITS     = 32;
	localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
	localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
	localparam int ENTRY_BITS    = 2 * ADDR_BITS;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOFIT   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_OVERLAP = 3'd3;
	localparam logic [2:0] ST_ZERO    = 3'd4;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_UPDATE,
		S_DONE
	} fla_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_GRANT_DROP,
		OP_GRANT_TRIM,
		OP_JOIN_BOTH,
		OP_JOIN_PREV,
		OP_JOIN_NEXT,
		OP_INSERT
	} fla_op_t;

	typedef struct packed {
		logic                load_req;
		logic                clr_scan;
		logic                chk;
		logic                set_decide;
		logic                rd_shift;
		logic                wr_shift;
		logic                wr_update;
		logic                rd_prev;
		logic                load_out;
	} fla_cmd_t;

	typedef struct packed {
		logic                scan_end;
		logic                scan_stop;
		logic                need_shift;
		logic                need_prev;
		fla_op_t             op;
	} fla_sts_t;
endpackage

>>> sv/fla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> sv/fla_datapath.sv
// Datapath: request registers, region table, scan, shift and update logic.
module fla_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fit_policy,
	input  logic                          kind,
	input  logic [fla_pkg::ADDR_BITS-1:0] block_size,
	input  logic [fla_pkg::ADDR_BITS-1:0] region_base,
	input  fla_pkg::fla_cmd_t             cmd,
	output fla_pkg::fla_sts_t             sts,
	output logic [2:0]                    status,
	output logic [fla_pkg::ADDR_BITS-1:0] granted_base,
	output logic [fla_pkg::CNT_BITS-1:0]  free_regions
);
	import fla_pkg::*;

	localparam int LW = ADDR_BITS + 1;

	logic                 kind_q;
	logic [ADDR_BITS-1:0] size_q;
	logic [ADDR_BITS-1:0] base_q;
	logic [LW-1:0]        end_q;
	logic                 pol_q;
	logic [CNT_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  idx_q;
	logic                 found_q;
	logic [IDX_BITS-1:0]  pick_q;
	logic [LW-1:0]        best_q;
	logic [ADDR_BITS-1:0] pick_base_q;
	logic [ADDR_BITS-1:0] pick_last_q;
	logic                 stop_q;
	logic [ADDR_BITS-1:0] next_base_q;
	logic [ADDR_BITS-1:0] next_last_q;
	logic [ADDR_BITS-1:0] prev_last_q;
	logic                 has_next_q;
	logic [2:0]           err_q;
	fla_op_t              op_q;
	logic [CNT_BITS-1:0]  sh_q;

	logic                 we;
	logic [IDX_BITS-1:0]  waddr;
	logic [ENTRY_BITS-1:0] wdata;
	logic [IDX_BITS-1:0]  raddr;
	logic [ENTRY_BITS-1:0] rdata;
	logic [ADDR_BITS-1:0] r_base;
	logic [ADDR_BITS-1:0] r_last;
	logic [LW-1:0]        r_len;
	logic [LW-1:0]        req_len;
	logic [LW-1:0]        pick_len;
	logic [LW-1:0]        prev_end;
	logic                 join_prev;
	logic                 join_next;
	logic                 has_prev;

	fla_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign r_base   = rdata[ENTRY_BITS-1:ADDR_BITS];
	assign r_last   = rdata[ADDR_BITS-1:0];
	assign r_len    = {1'b0, r_last} - {1'b0, r_base} + LW'(1);
	assign req_len  = {1'b0, size_q};
	assign pick_len = {1'b0, pick_last_q} - {1'b0, pick_base_q} + LW'(1);
	assign has_prev = (idx_q != '0);
	assign prev_end = {1'b0, prev_last_q} + LW'(1);
	assign join_prev = has_prev && (prev_end == {1'b0, base_q});
	assign join_next = has_next_q && ({1'b0, next_base_q} == end_q);

	// Read address: scan index, shift source, or predecessor
	always_comb begin
		raddr = idx_q[IDX_BITS-1:0];
		if (cmd.rd_shift) begin
			if (op_q == OP_INSERT) begin
				raddr = IDX_BITS'(sh_q - CNT_BITS'(1));
			end else begin
				raddr = IDX_BITS'(sh_q + CNT_BITS'(1));
			end
		end else if (cmd.rd_prev) begin
			raddr = IDX_BITS'(idx_q - CNT_BITS'(1));
		end
	end

	// Write port: shift move or final update
	always_comb begin
		we    = 1'b0;
		waddr = sh_q[IDX_BITS-1:0];
		wdata = rdata;
		if (cmd.wr_shift) begin
			we = 1'b1;
		end else if (cmd.wr_update) begin
			case (op_q)
				OP_GRANT_TRIM: begin
					we    = 1'b1;
					waddr = pick_q;
					wdata = {pick_base_q + size_q, pick_last_q};
				end
				OP_JOIN_BOTH: begin
					we    = 1'b1;
					waddr = IDX_BITS'(idx_q - CNT_BITS'(1));
					wdata = {r_base, next_last_q};
				end
				OP_JOIN_PREV: begin
					we    = 1'b1;
					waddr = IDX_BITS'(idx_q - CNT_BITS'(1));
					wdata = {r_base, end_q[ADDR_BITS-1:0] - ADDR_BITS'(1)};
				end
				OP_JOIN_NEXT: begin
					we    = 1'b1;
					waddr = idx_q[IDX_BITS-1:0];
					wdata = {base_q, next_last_q};
				end
				OP_INSERT: begin
					we    = 1'b1;
					waddr = idx_q[IDX_BITS-1:0];
					wdata = {base_q, ADDR_BITS'(end_q - LW'(1))};
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	assign sts.scan_end   = (idx_q == count_q);
	assign sts.scan_stop  = stop_q;
	assign sts.op         = op_q;
	assign sts.need_prev  = (op_q == OP_JOIN_BOTH) || (op_q == OP_JOIN_PREV);
	assign sts.need_shift = (op_q == OP_INSERT) ? (sh_q != idx_q)
		: (sh_q + CNT_BITS'(1) < count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.wr_update) begin
			case (op_q)
				OP_GRANT_DROP, OP_JOIN_BOTH: count_q <= count_q - CNT_BITS'(1);
				OP_INSERT:                   count_q <= count_q + CNT_BITS'(1);
				default:                     count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q <= kind;
			size_q <= block_size;
			base_q <= region_base;
			end_q  <= {1'b0, region_base} + {1'b0, block_size};
			pol_q  <= fit_policy;
		end
		if (cmd.clr_scan) begin
			idx_q      <= '0;
			found_q    <= 1'b0;
			stop_q     <= 1'b0;
			has_next_q <= 1'b0;
			best_q     <= '0;
			pick_q     <= '0;
		end
		// Examine one entry per visit
		if (cmd.chk) begin
			if (kind_q == KIND_ALLOC) begin
				if (r_len >= req_len && (!found_q || r_len < best_q)) begin
					found_q     <= 1'b1;
					best_q      <= r_len;
					pick_q      <= idx_q[IDX_BITS-1:0];
					pick_base_q <= r_base;
					pick_last_q <= r_last;
					stop_q      <= !pol_q;
				end
				if (!(r_len >= req_len && !pol_q && !found_q)) begin
					idx_q <= idx_q + CNT_BITS'(1);
				end
			end else if (r_base >= base_q) begin
				stop_q      <= 1'b1;
				has_next_q  <= 1'b1;
				next_base_q <= r_base;
				next_last_q <= r_last;
			end else begin
				prev_last_q <= r_last;
				idx_q       <= idx_q + CNT_BITS'(1);
			end
		end
		// Classify the request once the scan settles
		if (cmd.set_decide) begin
			if (size_q == '0) begin
				err_q <= ST_ZERO;
				op_q  <= OP_NONE;
			end else if (kind_q == KIND_ALLOC) begin
				if (!found_q) begin
					err_q <= ST_NOFIT;
					op_q  <= OP_NONE;
				end else if (pick_len == req_len) begin
					err_q <= ST_OK;
					op_q  <= OP_GRANT_DROP;
					sh_q  <= CNT_BITS'(pick_q);
				end else begin
					err_q <= ST_OK;
					op_q  <= OP_GRANT_TRIM;
				end
			end else if (end_q[ADDR_BITS] && end_q[ADDR_BITS-1:0] != '0) begin
				err_q <= ST_OVERLAP;
				op_q  <= OP_NONE;
			end else if (has_prev && prev_end > {1'b0, base_q}) begin
				err_q <= ST_OVERLAP;
				op_q  <= OP_NONE;
			end else if (has_next_q && {1'b0, next_base_q} < end_q) begin
				err_q <= ST_OVERLAP;
				op_q  <= OP_NONE;
			end else if (join_prev && join_next) begin
				err_q <= ST_OK;
				op_q  <= OP_JOIN_BOTH;
				sh_q  <= idx_q;
			end else if (join_prev) begin
				err_q <= ST_OK;
				op_q  <= OP_JOIN_PREV;
			end else if (join_next) begin
				err_q <= ST_OK;
				op_q  <= OP_JOIN_NEXT;
			end else if (count_q >= CNT_BITS'(TABLE_ENTRIES)) begin
				err_q <= ST_FULL;
				op_q  <= OP_NONE;
			end else begin
				err_q <= ST_OK;
				op_q  <= OP_INSERT;
				sh_q  <= count_q;
			end
		end
		if (cmd.wr_shift) begin
			if (op_q == OP_INSERT) begin
				sh_q <= sh_q - CNT_BITS'(1);
			end else begin
				sh_q <= sh_q + CNT_BITS'(1);
			end
		end
		if (cmd.load_out) begin
			status       <= err_q;
			granted_base <= (err_q == ST_OK && kind_q == KIND_ALLOC) ? pick_base_q : '0;
			free_regions <= count_q;
		end
	end
endmodule

>>> sv/fla_ctrl.sv
// Controller: request sequencing state machine and output handshake.
module fla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  fla_pkg::fla_sts_t sts,
	output fla_pkg::fla_cmd_t cmd
);
	import fla_pkg::*;

	fla_state_t state_q, state_d;
	logic       out_valid_q;

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					cmd.load_req = 1'b1;
					cmd.clr_scan = 1'b1;
					state_d      = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (sts.scan_end || sts.scan_stop) begin
					state_d = S_DECIDE;
				end else begin
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				cmd.chk = 1'b1;
				state_d = S_SCAN_RD;
			end
			S_DECIDE: begin
				cmd.set_decide = 1'b1;
				state_d        = S_SHIFT_RD;
			end
			S_SHIFT_RD: begin
				if (sts.op == OP_INSERT || sts.op == OP_GRANT_DROP
					|| sts.op == OP_JOIN_BOTH) begin
					if (sts.need_shift) begin
						cmd.rd_shift = 1'b1;
						state_d      = S_SHIFT_WR;
					end else begin
						cmd.rd_prev = sts.need_prev;
						state_d     = S_UPDATE;
					end
				end else begin
					cmd.rd_prev = sts.need_prev;
					state_d     = S_UPDATE;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			S_UPDATE: begin
				cmd.wr_update = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				// Hold until the previous result has left the output register
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while a request is in progress");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (state_q == S_IDLE) && out_valid)
		else $error("result not presented after completion");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_shift && cmd.wr_update))
		else $error("two table writes in one cycle");
endmodule

>>> sv/free_list_block_allocator.sv
// Top level of the free-list block allocator: controller, datapath, config register.
// A request (allocate or free) is taken when in_valid is high and in_stall low; one result
// transfer follows for every request. The block works on one request at a time: it walks
// the address-sorted region table through a single read port, a read state and a check state
// per entry visited, then moves entries one place (a read and a write state per moved
// entry) when a region is removed or inserted, then writes the update. The table holds
// at most 64 regions. The next request may be taken while the previous result still waits;
// its own result is then held back until the waiting one has transferred. The table has
// no clearing pass: the region count starts at zero after reset and only entries below it
// are read. fit_policy is written over its own valid/ready port; the user must write it
// only while the block is idle, as the block itself does not enforce this. It is sampled
// when a request is taken.
module free_list_block_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [fla_pkg::ADDR_BITS-1:0] block_size,
	input  logic [fla_pkg::ADDR_BITS-1:0] region_base,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic [fla_pkg::ADDR_BITS-1:0] granted_base,
	output logic [fla_pkg::CNT_BITS-1:0]  free_regions,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);
	import fla_pkg::*;

	fla_cmd_t cmd;
	fla_sts_t sts;
	logic     fit_policy_q;

	// Always accept configuration; hold the policy bit until rewritten
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			fit_policy_q <= cfg_data;
		end
	end

	fla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fla_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.fit_policy   (fit_policy_q),
		.kind         (kind),
		.block_size   (block_size),
		.region_base  (region_base),
		.cmd          (cmd),
		.sts          (sts),
		.status       (status),
		.granted_base (granted_base),
		.free_regions (free_regions)
	);
endmodule
